>>> rtl/joystick_stepper_jog_control_defines.svh
// Assertion macros shared by the checker of the jog control block.
`ifndef JOYSTICK_STEPPER_JOG_CONTROL_DEFINES_SVH
`define JOYSTICK_STEPPER_JOG_CONTROL_DEFINES_SVH

// Check cons in the same cycle as ante.
`define JSJ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jog control check failed");

// Check cons in the cycle after ante.
`define JSJ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jog control check failed");

`endif

>>> rtl/jsj_pkg.sv
package jsj_pkg;

  // Sample geometry
  localparam int SAMPLE_BITS = 12;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_FULL = '1;

  localparam int WAIT_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int PROD_BITS = SAMPLE_BITS + WAIT_BITS;

  // Divider runs one quotient bit per step
  localparam int DIV_STEPS = WAIT_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD_BAND = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FASTEST   = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SLOWEST   = 2'd3;

  // Register reset values
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET    = 12'd2048;
  localparam logic [SAMPLE_BITS-1:0] DEAD_BAND_RESET = 12'd500;
  localparam logic [WAIT_BITS-1:0]   FASTEST_RESET   = 8'd2;
  localparam logic [WAIT_BITS-1:0]   SLOWEST_RESET   = 8'd20;

  // Motion status codes
  localparam logic [1:0] STATUS_LIMIT = 2'd0;
  localparam logic [1:0] STATUS_BAND  = 2'd1;
  localparam logic [1:0] STATUS_PULSE = 2'd2;
  localparam logic [1:0] STATUS_WAIT  = 2'd3;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] stick_sample;
    logic                   limit_pressed;
  } sample_t;

  typedef struct packed {
    logic                 step_level;
    logic                 turn_ccw;
    logic [1:0]           motion_status;
    logic [WAIT_BITS-1:0] chosen_wait;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } jsj_state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic load_quick;
    logic mul;
    logic div_step;
    logic load_calc;
  } jsj_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic quick;
    logic out_free;
  } jsj_status_t;

endpackage

>>> rtl/jsj_ctrl.sv
module jsj_ctrl import jsj_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  jsj_status_t stat,
  output jsj_cmd_t    cmd
);

  jsj_state_t              state;
  jsj_state_t              state_next;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic                    accept;

  // Take a request only when idle and the result register can be loaded
  assign accept = sample_valid && (state == S_IDLE) && stat.out_free;

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL) begin
        div_cnt <= '0;
      end else if (state == S_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !stat.quick) state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DIV_LAST) state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd          = '0;
    sample_stall = 1'b1;
    case (state)
      S_IDLE: begin
        sample_stall   = !stat.out_free;
        cmd.capture    = accept && !stat.quick;
        cmd.load_quick = accept && stat.quick;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_DONE: begin
        cmd.load_calc = stat.out_free;
      end
      default: begin
        sample_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/jsj_dpath.sv
module jsj_dpath import jsj_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  sample_t                   sample,
  input  jsj_cmd_t                  cmd,
  output jsj_status_t               stat,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result
);

  logic [SAMPLE_BITS-1:0] center_value;
  logic [SAMPLE_BITS-1:0] dead_band;
  logic [WAIT_BITS-1:0]   fastest_wait;
  logic [WAIT_BITS-1:0]   slowest_wait;

  logic                   direction_reg;
  logic [WAIT_BITS-1:0]   wait_left;
  logic [WAIT_BITS-1:0]   last_wait;

  logic [SAMPLE_BITS-1:0] dist_val;
  logic [SAMPLE_BITS-1:0] range_val;
  logic                   dir_pend;
  logic [SAMPLE_BITS-1:0] rem;
  logic [WAIT_BITS-1:0]   low_bits;
  logic [WAIT_BITS-1:0]   quot;

  logic [SAMPLE_BITS-1:0] ccw_dist;
  logic [SAMPLE_BITS-1:0] cw_dist;
  logic                   go_ccw;
  logic                   go_cw;
  logic                   in_band;
  logic                   stopped;
  logic [SAMPLE_BITS-1:0] sel_range;
  logic                   trivial;
  logic [WAIT_BITS-1:0]   span;
  logic [PROD_BITS-1:0]   prod;
  logic [SAMPLE_BITS:0]   shifted;
  logic                   fits;
  logic [SAMPLE_BITS:0]   reduced;
  logic [WAIT_BITS-1:0]   calc_wait;
  result_t                quick_res;

  // Classify the sample against the dead band
  assign ccw_dist  = center_value - sample.stick_sample;
  assign cw_dist   = sample.stick_sample - center_value;
  assign go_ccw    = (center_value >= sample.stick_sample) && (ccw_dist >= dead_band);
  assign go_cw     = (sample.stick_sample > center_value) && (cw_dist >= dead_band);
  assign in_band   = !go_ccw && !go_cw;
  assign stopped   = sample.limit_pressed || in_band;
  assign sel_range = go_ccw ? center_value : SAMPLE_FULL - center_value;
  assign trivial   = (sel_range == '0) || (fastest_wait >= slowest_wait);

  assign stat.quick    = (wait_left != '0) || stopped || trivial;
  assign stat.out_free = !result_valid || !result_stall;

  // Result for ticks that need no divide
  always_comb begin
    quick_res = '0;
    quick_res.turn_ccw = direction_reg;
    if (wait_left != '0) begin
      quick_res.motion_status = STATUS_WAIT;
      quick_res.chosen_wait   = last_wait;
    end else if (sample.limit_pressed) begin
      quick_res.motion_status = STATUS_LIMIT;
    end else if (in_band) begin
      quick_res.motion_status = STATUS_BAND;
    end else begin
      quick_res.step_level    = 1'b1;
      quick_res.turn_ccw      = go_ccw;
      quick_res.motion_status = STATUS_PULSE;
      quick_res.chosen_wait   = slowest_wait;
    end
  end

  // Scale distance by the wait span, then divide by the range one bit per step
  assign span      = slowest_wait - fastest_wait;
  assign prod      = PROD_BITS'(dist_val) * PROD_BITS'(span);
  assign shifted   = {rem, low_bits[WAIT_BITS-1]};
  assign fits      = shifted >= {1'b0, range_val};
  assign reduced   = shifted - {1'b0, range_val};
  assign calc_wait = slowest_wait - quot;

  // Configuration and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      center_value  <= CENTER_RESET;
      dead_band     <= DEAD_BAND_RESET;
      fastest_wait  <= FASTEST_RESET;
      slowest_wait  <= SLOWEST_RESET;
      direction_reg <= 1'b0;
      wait_left     <= '0;
      last_wait     <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CENTER:    center_value <= cfg_data;
          REG_DEAD_BAND: dead_band    <= cfg_data;
          REG_FASTEST:   fastest_wait <= cfg_data[WAIT_BITS-1:0];
          REG_SLOWEST:   slowest_wait <= cfg_data[WAIT_BITS-1:0];
          default: ;
        endcase
      end

      if (cmd.load_quick) begin
        if (wait_left != '0) begin
          wait_left <= wait_left - 1'b1;
        end else if (!stopped) begin
          direction_reg <= go_ccw;
          last_wait     <= slowest_wait;
          wait_left     <= slowest_wait;
        end
      end else if (cmd.load_calc) begin
        direction_reg <= dir_pend;
        last_wait     <= calc_wait;
        wait_left     <= calc_wait;
      end

      // Hold the result until it is taken
      if (cmd.load_quick || cmd.load_calc) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Operands, divider and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dist_val  <= go_ccw ? ccw_dist : cw_dist;
      range_val <= sel_range;
      dir_pend  <= go_ccw;
    end
    if (cmd.mul) begin
      rem      <= prod[PROD_BITS-1:WAIT_BITS];
      low_bits <= prod[WAIT_BITS-1:0];
      quot     <= '0;
    end else if (cmd.div_step) begin
      rem      <= fits ? reduced[SAMPLE_BITS-1:0] : shifted[SAMPLE_BITS-1:0];
      low_bits <= {low_bits[WAIT_BITS-2:0], 1'b0};
      quot     <= {quot[WAIT_BITS-2:0], fits};
    end
    if (cmd.load_quick) begin
      result <= quick_res;
    end else if (cmd.load_calc) begin
      result.step_level    <= 1'b1;
      result.turn_ccw      <= dir_pend;
      result.motion_status <= STATUS_PULSE;
      result.chosen_wait   <= calc_wait;
    end
  end

endmodule

>>> rtl/joystick_stepper_jog_control.sv
// Joystick jog control for a step/direction stepper driver. Each request is one
// millisecond tick with a joystick sample and the limit-switch level, and gives exactly
// one result: the STEP level, the direction, a status and the low time chosen for the
// current step. Registers (index: name): 0 center_value, 1 dead_band, 2 fastest_wait,
// 3 slowest_wait; write them only while no request is in flight. A tick that is waiting
// out a step, stopped by the limit or inside the dead band, or that maps onto an empty
// range or a fastest wait not below the slowest, needs no divide: its result is
// registered at the edge that takes the request. Any other tick goes from request to
// result through the distance capture, the distance-times-span multiply, the bit-serial
// restoring divide by the range and the result load, which waits until the result
// register is free. One request is in flight at a time, and a request is taken only
// while the result register is free or being emptied.
module joystick_stepper_jog_control import jsj_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      sample_valid,
  output logic                      sample_stall,
  input  sample_t                   sample,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result
);

  jsj_cmd_t    cmd;
  jsj_status_t stat;

  jsj_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  jsj_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> rtl/jsj_checker.sv
`include "joystick_stepper_jog_control_defines.svh"

module jsj_checker import jsj_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input sample_t sample,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  logic stalled_in;
  logic stalled_out;
  logic is_pulse;
  logic is_stop;

  assign stalled_in  = sample_valid && sample_stall;
  assign stalled_out = result_valid && result_stall;
  assign is_pulse    = result.motion_status == STATUS_PULSE;
  assign is_stop     = (result.motion_status == STATUS_LIMIT) ||
                       (result.motion_status == STATUS_BAND);

  // Hold a stalled result
  `JSJ_ASSERT_NEXT(a_result_hold, stalled_out, result_valid && $stable(result))

  // Hold a stalled request
  `JSJ_ASSERT_NEXT(a_request_hold, stalled_in, sample_valid && $stable(sample))

  // Take no request while a finished result is stalled
  `JSJ_ASSERT_NOW(a_no_take_when_full, stalled_out, sample_stall)

  // Drive STEP high exactly on pulse ticks
  `JSJ_ASSERT_NOW(a_step_matches_status, result_valid, result.step_level == is_pulse)

  // Report no low time when stopped
  `JSJ_ASSERT_NOW(a_stop_has_no_wait, result_valid && is_stop, result.chosen_wait == '0)

endmodule

bind joystick_stepper_jog_control jsj_checker u_jsj_checker (.*);
